/* src/gts_pkg.sv */
package gts_pkg;

    // Token kind codes.
    localparam logic [5:0] KIND_NUMBER  = 6'd0;
    localparam logic [5:0] KIND_COMMENT = 6'd1;
    localparam logic [5:0] KIND_EQUAL   = 6'd2;
    localparam logic [5:0] KIND_PERCENT = 6'd3;
    localparam logic [5:0] KIND_COLON   = 6'd4;
    localparam logic [5:0] KIND_SLASH   = 6'd5;
    localparam logic [5:0] KIND_EOB     = 6'd6;
    localparam logic [5:0] KIND_UNKNOWN = 6'd7;
    localparam logic [5:0] KIND_EOF     = 6'd8;
    localparam logic [5:0] KIND_LETTER0 = 6'd9;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // One request: a character or the end-of-text mark.
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_request;

    // One token result.
    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        lex_error;
        logic        last_of_run;
    } t_result;

    // What a character does when no token is open.
    typedef enum logic [1:0] {
        CL_NUMBER,
        CL_COMMENT,
        CL_SKIP,
        CL_TOKEN
    } t_char_class;

    typedef struct packed {
        t_char_class cls;
        logic [5:0]  kind;
    } t_char_info;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Letter codes follow the order N O G X Y Z U V W P Q R A B C I J K E F S D T M.
    function automatic logic [5:0] letter_kind(input logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            8'h4E: k = KIND_LETTER0 + 6'd0;
            8'h4F: k = KIND_LETTER0 + 6'd1;
            8'h47: k = KIND_LETTER0 + 6'd2;
            8'h58: k = KIND_LETTER0 + 6'd3;
            8'h59: k = KIND_LETTER0 + 6'd4;
            8'h5A: k = KIND_LETTER0 + 6'd5;
            8'h55: k = KIND_LETTER0 + 6'd6;
            8'h56: k = KIND_LETTER0 + 6'd7;
            8'h57: k = KIND_LETTER0 + 6'd8;
            8'h50: k = KIND_LETTER0 + 6'd9;
            8'h51: k = KIND_LETTER0 + 6'd10;
            8'h52: k = KIND_LETTER0 + 6'd11;
            8'h41: k = KIND_LETTER0 + 6'd12;
            8'h42: k = KIND_LETTER0 + 6'd13;
            8'h43: k = KIND_LETTER0 + 6'd14;
            8'h49: k = KIND_LETTER0 + 6'd15;
            8'h4A: k = KIND_LETTER0 + 6'd16;
            8'h4B: k = KIND_LETTER0 + 6'd17;
            8'h45: k = KIND_LETTER0 + 6'd18;
            8'h46: k = KIND_LETTER0 + 6'd19;
            8'h53: k = KIND_LETTER0 + 6'd20;
            8'h44: k = KIND_LETTER0 + 6'd21;
            8'h54: k = KIND_LETTER0 + 6'd22;
            8'h4D: k = KIND_LETTER0 + 6'd23;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // Classifies a character seen while no token is open.
    function automatic t_char_info classify(input logic [7:0] c);
        t_char_info info;
        info.cls  = CL_TOKEN;
        info.kind = KIND_UNKNOWN;
        if (c == CH_PLUS || c == CH_MINUS || c == CH_DOT || is_digit(c)) begin
            info.cls = CL_NUMBER;
        end else if (c == CH_LPAREN) begin
            info.cls = CL_COMMENT;
        end else if (c == CH_EQUAL) begin
            info.kind = KIND_EQUAL;
        end else if (c == CH_PCT) begin
            info.kind = KIND_PERCENT;
        end else if (c == CH_COLON) begin
            info.kind = KIND_COLON;
        end else if (c == CH_SLASH) begin
            info.kind = KIND_SLASH;
        end else if (c == CH_LF) begin
            info.kind = KIND_EOB;
        end else if (c == CH_TAB || c == CH_CR || c == CH_DEL || c == CH_SPACE) begin
            info.cls = CL_SKIP;
        end else begin
            // Lowercase and unlisted letters fall out as unknown here.
            info.kind = letter_kind(c);
        end
        return info;
    endfunction

endpackage

/* src/gcode_token_scanner_unit.sv */
// A request is captured in the input register on acceptance and scanned from
// there; its tokens go into the result queue, whose head is offered on the output.
// Throughput: one request per cycle while the result queue has room for two more
// tokens; a request that yields two tokens is absorbed by a four-entry result queue.
// Reset (synchronous, active low) empties the pipeline and queue and clears the
// scan mode, character position, token start and leading-dot flag.
module gcode_token_scanner_unit #(
    parameter int POSITION_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gts_pkg::t_request i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output gts_pkg::t_result  o_out_data
);

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_FRAC,
        MODE_COMMENT,
        MODE_ERROR
    } t_mode;

    typedef logic [POSITION_BITS-1:0] t_pos;

    // Registers.
    logic              r_in_valid;
    gts_pkg::t_request r_in;
    t_mode             r_mode, n_mode;
    t_pos              r_pos, n_pos;
    t_pos              r_start, n_start;
    logic              r_dot, n_dot;
    gts_pkg::t_result  r_q [QUEUE_DEPTH];
    logic [1:0]        r_head, r_tail;
    logic [2:0]        r_count;

    // Handshake and queue control.
    logic       in_accept;
    logic       pop;
    logic       move;
    logic [2:0] count_after_pop;

    // Results of the scan of the registered request.
    gts_pkg::t_result res [2];
    logic [1:0]       res_n;
    logic             idle_go;
    t_pos             idle_pos;
    t_pos             pos_inc;
    t_pos             comment_len;
    gts_pkg::t_char_info info;

    assign pop             = o_out_valid && i_out_ready;
    assign count_after_pop = r_count - {2'b00, pop};
    assign move            = r_in_valid && (count_after_pop <= 3'd2);
    assign o_in_ready      = !r_in_valid || move;
    assign in_accept       = i_in_valid && o_in_ready;
    assign o_out_valid     = (r_count != 3'd0);
    assign o_out_data      = r_q[r_head];

    assign pos_inc     = r_pos + t_pos'(1);
    assign comment_len = pos_inc - r_start;

    // Scan one request against the current state.
    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_start  = r_start;
        n_dot    = r_dot;
        res[0]   = '0;
        res[1]   = '0;
        res_n    = 2'd0;
        idle_go  = 1'b0;
        idle_pos = r_pos;
        info     = gts_pkg::classify(r_in.char_code);

        if (r_in.end_of_text) begin
            // Flush any open token, then report end of file and clear.
            if (r_mode == MODE_INT || r_mode == MODE_FRAC || r_mode == MODE_COMMENT) begin
                res[0].token_kind   = (r_mode == MODE_COMMENT) ? gts_pkg::KIND_COMMENT
                                                               : gts_pkg::KIND_NUMBER;
                res[0].token_start  = 16'(r_start);
                res[0].token_length = 16'(r_pos - r_start);
                res_n               = 2'd1;
            end
            res[res_n[0]].token_kind  = gts_pkg::KIND_EOF;
            res[res_n[0]].token_start = 16'(r_pos);
            res_n                     = res_n + 2'd1;
            n_mode  = MODE_IDLE;
            n_pos   = '0;
            n_start = '0;
            n_dot   = 1'b0;
        end else if (r_mode == MODE_ERROR) begin
            // Characters are dropped until the end mark.
            n_mode = MODE_ERROR;
        end else if (&r_pos) begin
            // Position range exhausted: refuse the character.
            res[0].token_kind   = gts_pkg::KIND_UNKNOWN;
            res[0].token_start  = 16'(r_pos);
            res[0].token_length = 16'd1;
            res[0].lex_error    = 1'b1;
            res_n               = 2'd1;
            n_mode              = MODE_ERROR;
        end else begin
            unique case (r_mode)
                MODE_COMMENT: begin
                    if (r_in.char_code == gts_pkg::CH_COLON ||
                        r_in.char_code == gts_pkg::CH_PCT) begin
                        res[0].token_kind   = gts_pkg::KIND_UNKNOWN;
                        res[0].token_start  = 16'(r_pos);
                        res[0].token_length = 16'd1;
                        res[0].lex_error    = 1'b1;
                        res_n               = 2'd1;
                        n_mode              = MODE_ERROR;
                    end else begin
                        n_pos = pos_inc;
                        if (r_in.char_code == gts_pkg::CH_RPAREN) begin
                            res[0].token_kind   = gts_pkg::KIND_COMMENT;
                            res[0].token_start  = 16'(r_start);
                            res[0].token_length = 16'(comment_len);
                            res_n               = 2'd1;
                            n_mode              = MODE_IDLE;
                        end
                    end
                end
                MODE_INT, MODE_FRAC: begin
                    if (gts_pkg::is_digit(r_in.char_code)) begin
                        n_pos = pos_inc;
                    end else if (r_mode == MODE_INT && !r_dot &&
                                 r_in.char_code == gts_pkg::CH_DOT) begin
                        n_pos  = pos_inc;
                        n_mode = MODE_FRAC;
                    end else begin
                        // The number ends here; the character is scanned afresh.
                        res[0].token_kind   = gts_pkg::KIND_NUMBER;
                        res[0].token_start  = 16'(r_start);
                        res[0].token_length = 16'(r_pos - r_start);
                        res_n               = 2'd1;
                        idle_go             = 1'b1;
                    end
                end
                default: begin
                    idle_go = 1'b1;
                end
            endcase

            // A character met with no token open.
            if (idle_go) begin
                n_pos  = pos_inc;
                n_mode = MODE_IDLE;
                unique case (info.cls)
                    gts_pkg::CL_NUMBER: begin
                        n_start = idle_pos;
                        n_dot   = (r_in.char_code == gts_pkg::CH_DOT);
                        n_mode  = MODE_INT;
                    end
                    gts_pkg::CL_COMMENT: begin
                        n_start = idle_pos;
                        n_mode  = MODE_COMMENT;
                    end
                    gts_pkg::CL_SKIP: begin
                        n_mode = MODE_IDLE;
                    end
                    gts_pkg::CL_TOKEN: begin
                        res[res_n[0]].token_kind   = info.kind;
                        res[res_n[0]].token_start  = 16'(idle_pos);
                        res[res_n[0]].token_length = 16'd1;
                        res_n                      = res_n + 2'd1;
                    end
                    default: begin
                        n_mode = MODE_IDLE;
                    end
                endcase
            end
        end

        // Mark the final token of this request.
        if (res_n != 2'd0) begin
            res[res_n[0] ^ 1'b1].last_of_run = 1'b1;
        end
    end

    // Input register, scanner state and result queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_pos      <= '0;
            r_start    <= '0;
            r_dot      <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_mode  <= n_mode;
                r_pos   <= n_pos;
                r_start <= n_start;
                r_dot   <= n_dot;
                r_tail  <= r_tail + res_n;
                r_count <= count_after_pop + (move ? {1'b0, res_n} : 3'd0);
            end else begin
                r_count <= count_after_pop;
            end
            if (pop) begin
                r_head <= r_head + 2'd1;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
        if (move && res_n != 2'd0) begin
            r_q[r_tail] <= res[0];
        end
        if (move && res_n == 2'd2) begin
            r_q[r_tail + 2'd1] <= res[1];
        end
    end

endmodule

/* src/gts_checker.sv */
module gts_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input gts_pkg::t_request i_in_data,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input gts_pkg::t_result  o_out_data
);

    // A stalled token holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output token changed while stalled");

    // Reset leaves no token on the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("token offered right after reset");

    // End of file has zero length and closes its request.
    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.token_kind == gts_pkg::KIND_EOF |->
            o_out_data.token_length == 16'd0 && o_out_data.last_of_run &&
            !o_out_data.lex_error)
        else $error("malformed end-of-file token");

    // An error is a one-character unknown token and the last one of its request.
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.lex_error |->
            o_out_data.token_kind == gts_pkg::KIND_UNKNOWN &&
            o_out_data.token_length == 16'd1 && o_out_data.last_of_run)
        else $error("malformed error token");

    // Single-character kinds always have length one.
    a_single_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.token_kind != gts_pkg::KIND_NUMBER &&
        o_out_data.token_kind != gts_pkg::KIND_COMMENT &&
        o_out_data.token_kind != gts_pkg::KIND_EOF |->
            o_out_data.token_length == 16'd1)
        else $error("single-character token with wrong length");

endmodule

bind gcode_token_scanner_unit gts_checker u_gts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

/* bench/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int STALL_CYCLES = 300;

    // Scanner state as the testbench tracks it.
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_INT,
        SCAN_FRAC,
        SCAN_COMMENT,
        SCAN_ERROR
    } t_scan_mode;

    // One line of the directed sequence; want is used only when typed is set.
    typedef struct {
        gts_pkg::t_request req;
        bit                typed;
        gts_pkg::t_result  want;
    } t_script_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    gts_pkg::t_request i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    gts_pkg::t_result  o_out_data;

    // Tracked scanner state.
    t_scan_mode  scan_mode;
    logic [15:0] char_pos;
    logic [15:0] token_begin;
    bit          dot_first;

    gts_pkg::t_result fresh_tokens[$];
    gts_pkg::t_result awaited_tokens[$];
    t_script_row      script[$];

    int send_idle_pct;
    int recv_idle_pct;
    int stall_left;
    bit long_stall_due;
    int mismatch_count;
    int cycle_count;

    gcode_token_scanner_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d tokens outstanding", $time,
                     awaited_tokens.size());
            $display("status: fail");
            $finish;
        end
    end

    // Output side: random back-pressure, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (long_stall_due) begin
            stall_left = STALL_CYCLES;
            long_stall_due = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Every token taken from the block is compared with the oldest one predicted.
    always @(posedge i_clk) begin
        gts_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_tokens.size() == 0) begin
                mismatch_count++;
                $display({"%0t: expected no token, got kind %0d start %0d len %0d",
                          " err %0b last %0b"},
                         $time, o_out_data.token_kind, o_out_data.token_start,
                         o_out_data.token_length, o_out_data.lex_error,
                         o_out_data.last_of_run);
            end else begin
                want = awaited_tokens.pop_front();
                if (o_out_data !== want) begin
                    mismatch_count++;
                    $display({"%0t: expected kind %0d start %0d len %0d err %0b",
                              " last %0b, got kind %0d start %0d len %0d err %0b",
                              " last %0b"},
                             $time, want.token_kind, want.token_start,
                             want.token_length, want.lex_error, want.last_of_run,
                             o_out_data.token_kind, o_out_data.token_start,
                             o_out_data.token_length, o_out_data.lex_error,
                             o_out_data.last_of_run);
                end
            end
        end
    end

    function automatic gts_pkg::t_request ch(input logic [7:0] c);
        gts_pkg::t_request r;
        r.char_code = c;
        r.end_of_text = 1'b0;
        return r;
    endfunction

    function automatic gts_pkg::t_request end_mark();
        gts_pkg::t_request r;
        r.char_code = 8'($urandom_range(0, 255));
        r.end_of_text = 1'b1;
        return r;
    endfunction

    function automatic gts_pkg::t_result tok(input logic [5:0] kind,
                                             input logic [15:0] start,
                                             input logic [15:0] len, input logic err);
        gts_pkg::t_result t;
        t.token_kind = kind;
        t.token_start = start;
        t.token_length = len;
        t.lex_error = err;
        t.last_of_run = 1'b1;
        return t;
    endfunction

    function automatic void add_row(input gts_pkg::t_request req, input bit typed,
                                    input gts_pkg::t_result want);
        t_script_row row;
        row.req = req;
        row.typed = typed;
        row.want = want;
        script.push_back(row);
    endfunction

    function automatic logic [5:0] letter_code(input logic [7:0] c);
        string order;
        order = "NOGXYZUVWPQRABCIJKEFSDTM";
        for (int i = 0; i < 24; i++) begin
            if (order[i] == c) begin
                return gts_pkg::KIND_LETTER0 + 6'(i);
            end
        end
        return gts_pkg::KIND_UNKNOWN;
    endfunction

    function automatic void emit(input logic [5:0] kind, input logic [15:0] start,
                                 input logic [15:0] len, input logic err);
        gts_pkg::t_result t;
        t = tok(kind, start, len, err);
        t.last_of_run = 1'b0;
        fresh_tokens.push_back(t);
    endfunction

    function automatic void clear_scan();
        scan_mode = SCAN_IDLE;
        char_pos = '0;
        token_begin = '0;
        dot_first = 1'b0;
    endfunction

    // Predicts the tokens caused by one request into fresh_tokens.
    function automatic void lex_request(input gts_pkg::t_request req);
        logic [7:0]  c;
        logic [15:0] p;
        c = req.char_code;
        if (req.end_of_text) begin
            // Flush an open token, even an unclosed comment, then end of file.
            if (scan_mode == SCAN_INT || scan_mode == SCAN_FRAC) begin
                emit(gts_pkg::KIND_NUMBER, token_begin, char_pos - token_begin, 1'b0);
            end else if (scan_mode == SCAN_COMMENT) begin
                emit(gts_pkg::KIND_COMMENT, token_begin, char_pos - token_begin, 1'b0);
            end
            emit(gts_pkg::KIND_EOF, char_pos, 16'd0, 1'b0);
            clear_scan();
            return;
        end
        if (scan_mode == SCAN_ERROR) begin
            return;
        end
        // The last position is never used: the character there is refused.
        if (char_pos == 16'hFFFF) begin
            emit(gts_pkg::KIND_UNKNOWN, char_pos, 16'd1, 1'b1);
            scan_mode = SCAN_ERROR;
            return;
        end
        if (scan_mode == SCAN_COMMENT) begin
            if (c == gts_pkg::CH_COLON || c == gts_pkg::CH_PCT) begin
                emit(gts_pkg::KIND_UNKNOWN, char_pos, 16'd1, 1'b1);
                scan_mode = SCAN_ERROR;
                return;
            end
            char_pos++;
            if (c == gts_pkg::CH_RPAREN) begin
                emit(gts_pkg::KIND_COMMENT, token_begin, char_pos - token_begin, 1'b0);
                scan_mode = SCAN_IDLE;
            end
            return;
        end
        if (scan_mode == SCAN_INT || scan_mode == SCAN_FRAC) begin
            if (c >= gts_pkg::CH_ZERO && c <= gts_pkg::CH_NINE) begin
                char_pos++;
                return;
            end
            if (scan_mode == SCAN_INT && c == gts_pkg::CH_DOT && !dot_first) begin
                char_pos++;
                scan_mode = SCAN_FRAC;
                return;
            end
            // Anything else closes the number and is then scanned from idle.
            emit(gts_pkg::KIND_NUMBER, token_begin, char_pos - token_begin, 1'b0);
            scan_mode = SCAN_IDLE;
        end
        p = char_pos;
        char_pos++;
        if (c == gts_pkg::CH_PLUS || c == gts_pkg::CH_MINUS || c == gts_pkg::CH_DOT ||
            (c >= gts_pkg::CH_ZERO && c <= gts_pkg::CH_NINE)) begin
            token_begin = p;
            dot_first = (c == gts_pkg::CH_DOT);
            scan_mode = SCAN_INT;
        end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
            emit(letter_code(c), p, 16'd1, 1'b0);
        end else if (c == gts_pkg::CH_LPAREN) begin
            token_begin = p;
            scan_mode = SCAN_COMMENT;
        end else if (c == gts_pkg::CH_EQUAL) begin
            emit(gts_pkg::KIND_EQUAL, p, 16'd1, 1'b0);
        end else if (c == gts_pkg::CH_PCT) begin
            emit(gts_pkg::KIND_PERCENT, p, 16'd1, 1'b0);
        end else if (c == gts_pkg::CH_COLON) begin
            emit(gts_pkg::KIND_COLON, p, 16'd1, 1'b0);
        end else if (c == gts_pkg::CH_SLASH) begin
            emit(gts_pkg::KIND_SLASH, p, 16'd1, 1'b0);
        end else if (c == gts_pkg::CH_LF) begin
            emit(gts_pkg::KIND_EOB, p, 16'd1, 1'b0);
        end else if (c == gts_pkg::CH_TAB || c == gts_pkg::CH_CR ||
                     c == gts_pkg::CH_DEL || c == gts_pkg::CH_SPACE) begin
            // Whitespace is only counted.
        end else begin
            emit(gts_pkg::KIND_UNKNOWN, p, 16'd1, 1'b0);
        end
    endfunction

    // Mostly G-code shaped characters, with some raw bytes and end marks.
    function automatic gts_pkg::t_request random_gcode_char();
        gts_pkg::t_request r;
        int pick;
        r = ch(8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (scan_mode == SCAN_ERROR) begin
            // Leave the error state reasonably soon.
            if (pick < 25) begin
                r = end_mark();
            end
        end else if (pick < 30) begin
            r.char_code = gts_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        end else if (pick < 44) begin
            r.char_code = 8'h41 + 8'($urandom_range(0, 25));
        end else if (pick < 50) begin
            r.char_code = gts_pkg::CH_DOT;
        end else if (pick < 54) begin
            r.char_code = $urandom_range(0, 1) ? gts_pkg::CH_PLUS : gts_pkg::CH_MINUS;
        end else if (pick < 62) begin
            r.char_code = gts_pkg::CH_SPACE;
        end else if (pick < 67) begin
            r.char_code = gts_pkg::CH_LF;
        end else if (pick < 72) begin
            r.char_code = gts_pkg::CH_LPAREN;
        end else if (pick < 77) begin
            r.char_code = gts_pkg::CH_RPAREN;
        end else if (pick < 81) begin
            case ($urandom_range(0, 3))
                0: r.char_code = gts_pkg::CH_EQUAL;
                1: r.char_code = gts_pkg::CH_PCT;
                2: r.char_code = gts_pkg::CH_COLON;
                default: r.char_code = gts_pkg::CH_SLASH;
            endcase
        end else if (pick < 85) begin
            case ($urandom_range(0, 2))
                0: r.char_code = gts_pkg::CH_TAB;
                1: r.char_code = gts_pkg::CH_CR;
                default: r.char_code = gts_pkg::CH_DEL;
            endcase
        end else if (pick >= 98) begin
            r = end_mark();
        end
        return r;
    endfunction

    // Offers one request, holding it until the block takes it.
    task automatic send_request(input gts_pkg::t_request req);
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (o_in_ready) begin
                taken = 1'b1;
            end else begin
                @(negedge i_clk);
            end
        end
        @(negedge i_clk);
    endtask

    // Sends a request and queues the tokens it must produce.
    task automatic apply_request(input gts_pkg::t_request req, input bit typed,
                                 input gts_pkg::t_result want);
        send_request(req);
        fresh_tokens.delete();
        lex_request(req);
        if (fresh_tokens.size() > 0) begin
            fresh_tokens[fresh_tokens.size() - 1].last_of_run = 1'b1;
        end
        if (typed) begin
            awaited_tokens.push_back(want);
        end else begin
            foreach (fresh_tokens[i]) begin
                awaited_tokens.push_back(fresh_tokens[i]);
            end
        end
    endtask

    task automatic random_phase(input int send_pct, input int recv_pct, input int target,
                                input bit with_stall);
        int counted;
        bit live;
        gts_pkg::t_request r;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        counted = 0;
        while (counted < target) begin
            if (with_stall && counted == target / 3) begin
                long_stall_due = 1'b1;
                with_stall = 1'b0;
            end
            r = random_gcode_char();
            // Characters swallowed by the error state do not count.
            live = (scan_mode != SCAN_ERROR) || r.end_of_text;
            apply_request(r, 1'b0, '0);
            if (live) begin
                counted++;
            end
        end
    endtask

    initial begin
        gts_pkg::t_result none;
        none = '0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        stall_left = 0;
        long_stall_due = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        send_idle_pct = 13;
        recv_idle_pct = 50;
        clear_scan();

        // Directed sequence; comments give the position of each character.
        add_row(end_mark(), 1'b1, tok(gts_pkg::KIND_EOF, 16'd0, 16'd0, 1'b0));
        add_row(ch(8'h47), 1'b1,
                tok(gts_pkg::KIND_LETTER0 + 6'd2, 16'd0, 16'd1, 1'b0));
        add_row(ch(gts_pkg::CH_PLUS), 1'b0, none);        // 1: number opens
        add_row(ch(gts_pkg::CH_DOT), 1'b0, none);         // 2: fraction
        add_row(ch(gts_pkg::CH_NINE), 1'b0, none);        // 3
        add_row(ch(gts_pkg::CH_DOT), 1'b0, none);         // 4: second dot closes, opens a new one
        add_row(ch(gts_pkg::CH_DOT), 1'b0, none);         // 5: number began with a dot
        add_row(ch(8'h4D), 1'b0, none);                   // 6: letter closes number
        add_row(ch(gts_pkg::CH_LPAREN), 1'b0, none);      // 7
        add_row(ch(8'hFF), 1'b0, none);                   // 8: high byte inside comment
        add_row(ch(gts_pkg::CH_RPAREN), 1'b0, none);      // 9: comment of length 3
        add_row(ch(gts_pkg::CH_EQUAL), 1'b0, none);
        add_row(ch(gts_pkg::CH_PCT), 1'b0, none);
        add_row(ch(gts_pkg::CH_COLON), 1'b0, none);
        add_row(ch(gts_pkg::CH_SLASH), 1'b0, none);
        add_row(ch(gts_pkg::CH_LF), 1'b0, none);
        add_row(ch(gts_pkg::CH_TAB), 1'b0, none);
        add_row(ch(gts_pkg::CH_CR), 1'b0, none);
        add_row(ch(gts_pkg::CH_DEL), 1'b0, none);
        add_row(ch(gts_pkg::CH_SPACE), 1'b0, none);       // 18
        add_row(ch(8'h00), 1'b1, tok(gts_pkg::KIND_UNKNOWN, 16'd19, 16'd1, 1'b0));
        add_row(ch(8'h61), 1'b0, none);                   // 20: lowercase is unknown
        add_row(ch(gts_pkg::CH_MINUS), 1'b0, none);       // 21
        add_row(end_mark(), 1'b0, none);                  // flushes number, then end of file
        add_row(ch(gts_pkg::CH_LPAREN), 1'b0, none);
        add_row(end_mark(), 1'b0, none);                  // flushes unclosed comment
        add_row(ch(gts_pkg::CH_LPAREN), 1'b0, none);
        add_row(ch(gts_pkg::CH_PCT), 1'b1,
                tok(gts_pkg::KIND_UNKNOWN, 16'd1, 16'd1, 1'b1));
        add_row(ch(8'h4E), 1'b0, none);                   // ignored in the error state
        add_row(end_mark(), 1'b1, tok(gts_pkg::KIND_EOF, 16'd1, 16'd0, 1'b0));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[i]) begin
            apply_request(script[i].req, script[i].typed, script[i].want);
        end

        // Random text under three idling patterns, one long output hold-off.
        random_phase(13, 50, 200, 1'b1);
        random_phase(50, 13, 200, 1'b0);
        random_phase(0, 0, 200, 1'b0);
        i_in_valid <= 1'b0;

        while (awaited_tokens.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* files.f */
src/gts_pkg.sv
src/gcode_token_scanner_unit.sv
src/gts_checker.sv
bench/testbench.sv
